// File: rtl/lcc_pkg.sv
// ---------------------------------------------------------------------------
// lcc_pkg
// Shared types and constants for the lane crossing counter: field widths,
// register indexes, reset values, command codes, sequencer states and the divider status.
// ---------------------------------------------------------------------------
package lcc_pkg;

  // Field widths of the beats and registers
  localparam int CMD_W      = 1;
  localparam int LANE_W     = 5;
  localparam int MASS_W     = 27;
  localparam int MOMENT_W   = 36;
  localparam int COUNT_W    = 16;
  localparam int GATE_W     = 9;
  localparam int MARGIN_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;

  // Divider iteration count and its counter width
  localparam int DIV_STEPS = MOMENT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Register reset values
  localparam logic [GATE_W-1:0]   GATE_TOP_RST     = GATE_W'(300);
  localparam logic [GATE_W-1:0]   GATE_BOTTOM_RST  = GATE_W'(330);
  localparam logic [MASS_W-1:0]   MIN_MASS_RST     = MASS_W'(400);
  localparam logic [MARGIN_W-1:0] NEAR_MARGIN_RST  = MARGIN_W'(15);
  localparam logic [MARGIN_W-1:0] CLEAR_MARGIN_RST = MARGIN_W'(30);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_OBSERVE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_REPORT  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GATE_TOP     = 3'd0,
    REG_GATE_BOTTOM  = 3'd1,
    REG_MIN_MASS     = 3'd2,
    REG_NEAR_MARGIN  = 3'd3,
    REG_CLEAR_MARGIN = 3'd4
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RULE,
    ST_DIV,
    ST_DONE
  } state_t;

  // Divider result towards the sequencer
  typedef struct packed {
    logic                done;
    logic [MOMENT_W-1:0] quotient;
  } div_res_t;

endpackage

// File: rtl/lcc_div.sv
// ---------------------------------------------------------------------------
// lcc_div
// Iterative restoring divider: one quotient bit per cycle over the width of
// the moment sum. The quotient stays on its output until the next start.
// ---------------------------------------------------------------------------
module lcc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lcc_pkg::MOMENT_W-1:0] dividend,
  input  logic [lcc_pkg::MASS_W-1:0]   divisor,
  output lcc_pkg::div_res_t            res
);
  import lcc_pkg::*;

  logic [MOMENT_W-1:0]  quo;
  logic [MASS_W-1:0]    rem;
  logic [MASS_W-1:0]    dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 done;

  logic [MASS_W:0]      trial;
  logic                 fits;

  // Shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial = {rem, quo[MOMENT_W-1]};
    fits  = (trial >= {1'b0, dsr});
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= DIV_CNT_W'(DIV_STEPS);
      done <= 1'b0;
    end else begin
      done <= (cnt == DIV_CNT_W'(1));
      if (cnt != '0) begin
        cnt <= cnt - DIV_CNT_W'(1);
      end
    end
  end

  // Datapath: dividend register turns into the quotient bit by bit
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (cnt != '0) begin
      quo <= {quo[MOMENT_W-2:0], fits};
      rem <= fits ? MASS_W'(trial - {1'b0, dsr}) : trial[MASS_W-1:0];
    end
  end

  assign res.done     = done;
  assign res.quotient = quo;

endmodule

// File: rtl/lane_crossing_counter_unit.sv
// ---------------------------------------------------------------------------
// lane_crossing_counter_unit
// Timing: a report, a stray lane or a light blob goes from the rule state straight
//   to the done state; a heavy blob first passes through the divider state.
// Throughput: one beat at a time; the next beat is taken once the last one's result
//   is loaded into the output register, which waits while a result is stalled.
// Reset: synchronous; rows, latches and counts clear, registers take defaults.
// ---------------------------------------------------------------------------
module lane_crossing_counter_unit #(
  parameter int LANES    = 20,
  parameter int ROW_BITS = 9
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lcc_pkg::CMD_W-1:0]      command,
  input  logic [lcc_pkg::LANE_W-1:0]     lane,
  input  logic [lcc_pkg::MASS_W-1:0]     mass_sum,
  input  logic [lcc_pkg::MOMENT_W-1:0]   row_moment_sum,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lcc_pkg::COUNT_W-1:0]    entries,
  output logic [lcc_pkg::COUNT_W-1:0]    exits,
  output logic [ROW_BITS-1:0]            tracked_row,
  input  logic                           cfg_write,
  input  logic [lcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lcc_pkg::*;

  localparam int LI    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CW    = ((ROW_BITS > GATE_W) ? ROW_BITS : GATE_W) + 1;
  localparam int SUM_W = MOMENT_W + 1;
  localparam logic [ROW_BITS-1:0] ROW_MAX     = '1;
  localparam logic [SUM_W-1:0]    ROW_MAX_EXT = SUM_W'(ROW_MAX);

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    sat_inc = (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_W'(1);
  endfunction

  // Configuration registers
  logic [GATE_W-1:0]   gate_top;
  logic [GATE_W-1:0]   gate_bottom;
  logic [MASS_W-1:0]   min_mass;
  logic [MARGIN_W-1:0] near_margin;
  logic [MARGIN_W-1:0] clear_margin;

  // Lane state
  logic [ROW_BITS-1:0] latest_row [LANES];
  logic [ROW_BITS-1:0] older_row  [LANES];
  logic [LANES-1:0]    counted_latch;
  logic [COUNT_W-1:0]  entry_count;
  logic [COUNT_W-1:0]  exit_count;

  // Captured beat
  logic [CMD_W-1:0]    cmd_q;
  logic [LANE_W-1:0]   lane_q;
  logic [MASS_W-1:0]   mass_q;
  logic [MOMENT_W-1:0] moment_q;
  logic                heavy_q;

  state_t state, state_next;
  logic   in_take;
  logic   div_start;
  logic   load_out;
  div_res_t div_res;

  logic [LI-1:0]       idx;
  logic                lane_ok;
  logic                observe;
  logic                heavy;
  logic [CW-1:0]       lat_e, old_e, top_e, bot_e, nm_e, cm_e;
  logic                exit_hit, entry_hit, clear_hit;
  logic [SUM_W-1:0]    row_sum;
  logic [ROW_BITS-1:0] row_sat;
  logic [ROW_BITS-1:0] row_new;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_top     <= GATE_TOP_RST;
      gate_bottom  <= GATE_BOTTOM_RST;
      min_mass     <= MIN_MASS_RST;
      near_margin  <= NEAR_MARGIN_RST;
      clear_margin <= CLEAR_MARGIN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GATE_TOP:     gate_top     <= cfg_data[GATE_W-1:0];
        REG_GATE_BOTTOM:  gate_bottom  <= cfg_data[GATE_W-1:0];
        REG_MIN_MASS:     min_mass     <= cfg_data[MASS_W-1:0];
        REG_NEAR_MARGIN:  near_margin  <= cfg_data[MARGIN_W-1:0];
        REG_CLEAR_MARGIN: clear_margin <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_RULE;
      ST_RULE: state_next = heavy ? ST_DIV : ST_DONE;
      ST_DIV:  if (div_res.done) state_next = ST_DONE;
      ST_DONE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE: in_stall  = 1'b0;
      ST_RULE: div_start = heavy;
      ST_DIV:  ;
      ST_DONE: load_out  = !out_valid || !out_stall;
      default: ;
    endcase
  end

  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the beat
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_q    <= command;
      lane_q   <= lane;
      mass_q   <= mass_sum;
      moment_q <= row_moment_sum;
    end
  end

  // Lane decode and the counting rule on narrow, widened values
  always_comb begin
    idx     = lane_q[LI-1:0];
    lane_ok = ({1'b0, lane_q} < (LANE_W + 1)'(LANES));
    observe = (cmd_q == CMD_OBSERVE) && lane_ok;
    heavy   = observe && (mass_q > min_mass);
    lat_e   = CW'(latest_row[idx]);
    old_e   = CW'(older_row[idx]);
    top_e   = CW'(gate_top);
    bot_e   = CW'(gate_bottom);
    nm_e    = CW'(near_margin);
    cm_e    = CW'(clear_margin);
    exit_hit  = (old_e > lat_e) && (lat_e < top_e + nm_e) && !counted_latch[idx];
    entry_hit = (old_e < lat_e) && (lat_e + nm_e > bot_e) && !counted_latch[idx];
    clear_hit = (lat_e > top_e + cm_e) && (lat_e + cm_e < bot_e);
  end

  // New row from the quotient, saturated to the row range
  always_comb begin
    row_sum = {1'b0, div_res.quotient} + SUM_W'(gate_top);
    row_sat = (row_sum > ROW_MAX_EXT) ? ROW_MAX : row_sum[ROW_BITS-1:0];
    row_new = heavy_q ? row_sat : latest_row[idx];
  end

  // Lane state and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        latest_row[i] <= '0;
        older_row[i]  <= '0;
      end
      counted_latch <= '0;
      entry_count   <= '0;
      exit_count    <= '0;
      heavy_q       <= 1'b0;
    end else begin
      if (state == ST_RULE) begin
        heavy_q <= heavy;
        if (observe) begin
          older_row[idx] <= latest_row[idx];
          if (clear_hit) begin
            counted_latch[idx] <= 1'b0;
          end else if (exit_hit || entry_hit) begin
            counted_latch[idx] <= 1'b1;
          end
          if (exit_hit) begin
            exit_count <= sat_inc(exit_count);
          end else if (entry_hit) begin
            entry_count <= sat_inc(entry_count);
          end
        end
      end
      if (load_out) begin
        if (heavy_q) begin
          latest_row[idx] <= row_sat;
        end
        if (cmd_q == CMD_REPORT) begin
          entry_count <= '0;
          exit_count  <= '0;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      entries     <= entry_count;
      exits       <= exit_count;
      tracked_row <= observe ? row_new : '0;
    end
  end

  // Shared divider
  lcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (moment_q),
    .divisor  (mass_q),
    .res      (div_res)
  );

endmodule

// File: rtl/lcc_chk.sv
// ---------------------------------------------------------------------------
// lcc_chk
// Port-level checks on the lane crossing counter, bound to the top level.
// ---------------------------------------------------------------------------
module lcc_chk #(
  parameter int ROW_BITS = 9
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [lcc_pkg::COUNT_W-1:0]  entries,
  input logic [lcc_pkg::COUNT_W-1:0]  exits,
  input logic [ROW_BITS-1:0]          tracked_row
);
  import lcc_pkg::*;

  // A stalled result beat stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(entries) && $stable(exits)
      && $stable(tracked_row))
    else $error("stalled result beat changed");

  // An accepted input beat makes the block busy on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without a busy cycle");

  // A new result appears only while a beat is being worked on
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat with no beat in work");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat straight after reset");

endmodule

bind lane_crossing_counter_unit lcc_chk #(.ROW_BITS(ROW_BITS)) u_lcc_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .entries     (entries),
  .exits       (exits),
  .tracked_row (tracked_row)
);

// File: sim/lane_crossing_counter_unit_tb.sv
// ---------------------------------------------------------------------------
// lane_crossing_counter_unit_tb
// Self-checking bench for the lane crossing counter. A queue of beats feeds a
// clocked driver; each accepted beat runs through a local tally predictor and
// its expected counts and row are queued. A clocked monitor compares every
// result beat with the oldest expectation. Directed beats cover threshold,
// row saturation, stray lanes and reports; random phases under several
// register settings replay gate crossings.
// ---------------------------------------------------------------------------
module lane_crossing_counter_unit_tb;
  import lcc_pkg::*;

  localparam int LANES    = 20;
  localparam int ROW_BITS = 9;
  localparam int ROW_TOP  = (1 << ROW_BITS) - 1;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [LANE_W-1:0]   lane;
    logic [MASS_W-1:0]   mass;
    logic [MOMENT_W-1:0] moment;
  } beat_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  entries;
    logic [COUNT_W-1:0]  exits;
    logic [ROW_BITS-1:0] row;
  } tally_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [CMD_W-1:0]      command;
  logic [LANE_W-1:0]     lane;
  logic [MASS_W-1:0]     mass_sum;
  logic [MOMENT_W-1:0]   row_moment_sum;
  logic                  out_valid;
  logic                  out_stall;
  logic [COUNT_W-1:0]    entries;
  logic [COUNT_W-1:0]    exits;
  logic [ROW_BITS-1:0]   tracked_row;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor copy of the registers and lane state
  logic [GATE_W-1:0]   gate_top, gate_bottom;
  logic [MASS_W-1:0]   min_mass;
  logic [MARGIN_W-1:0] near_margin, clear_margin;
  logic [ROW_BITS-1:0] latest_row [LANES];
  logic [ROW_BITS-1:0] older_row [LANES];
  logic                lane_latched [LANES];
  logic [COUNT_W-1:0]  entry_cnt, exit_cnt;

  beat_t  pending_beats [$];
  tally_t tally_q [$];
  beat_t  cur_beat;
  tally_t want;
  int     idle_left, stall_left;
  bit     calm;
  int     errors;
  int     n_obs, n_reports, n_stray, n_entries, n_exits;
  bit     count_saturated;

  lane_crossing_counter_unit #(
    .LANES    (LANES),
    .ROW_BITS (ROW_BITS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .lane           (lane),
    .mass_sum       (mass_sum),
    .row_moment_sum (row_moment_sum),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .entries        (entries),
    .exits          (exits),
    .tracked_row    (tracked_row),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int draw_gap();
    int pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  // Advance the lane tally for one accepted beat and return its result
  function automatic tally_t tally_beat(beat_t b);
    tally_t r;
    int latest, move, top, bot, nm, cm;
    logic [63:0] quo;
    r.row = '0;
    if (b.command == CMD_REPORT) begin
      r.entries = entry_cnt;
      r.exits = exit_cnt;
      entry_cnt = '0;
      exit_cnt = '0;
      n_reports++;
      return r;
    end
    n_obs++;
    if (b.lane < LANES) begin
      latest = int'(latest_row[b.lane]);
      move = int'(older_row[b.lane]) - latest;
      top = int'(gate_top);
      bot = int'(gate_bottom);
      nm = int'(near_margin);
      cm = int'(clear_margin);
      if (move > 0 && latest < top + nm && !lane_latched[b.lane]) begin
        if (exit_cnt != COUNT_MAX) exit_cnt++;
        else count_saturated = 1'b1;
        lane_latched[b.lane] = 1'b1;
        n_exits++;
      end
      if (move < 0 && latest > bot - nm && !lane_latched[b.lane]) begin
        if (entry_cnt != COUNT_MAX) entry_cnt++;
        else count_saturated = 1'b1;
        lane_latched[b.lane] = 1'b1;
        n_entries++;
      end
      if (latest > top + cm && latest < bot - cm) lane_latched[b.lane] = 1'b0;
      older_row[b.lane] = latest_row[b.lane];
      if (b.mass > min_mass) begin
        quo = 64'(b.moment) / 64'(b.mass) + 64'(gate_top);
        latest_row[b.lane] = (quo > 64'(ROW_TOP)) ? ROW_BITS'(ROW_TOP) : quo[ROW_BITS-1:0];
      end
      r.row = latest_row[b.lane];
    end else begin
      n_stray++;
    end
    r.entries = entry_cnt;
    r.exits = exit_cnt;
    return r;
  endfunction

  // Heavy blob whose centroid lands on the given row
  function automatic beat_t aim(int ln, int row);
    beat_t bt;
    logic [63:0] span;
    if (row < int'(gate_top)) row = int'(gate_top);
    if (row > ROW_TOP) row = ROW_TOP;
    bt.command = CMD_OBSERVE;
    bt.lane = LANE_W'(ln);
    bt.mass = MASS_W'(min_mass + $urandom_range(1, 4000));
    span = 64'(row - int'(gate_top)) * 64'(bt.mass) + 64'($urandom_range(0, bt.mass - 1));
    bt.moment = span[MOMENT_W-1:0];
    return bt;
  endfunction

  // Blob too light to move the stored row
  function automatic beat_t light(int ln);
    beat_t bt;
    bt.command = CMD_OBSERVE;
    bt.lane = LANE_W'(ln);
    bt.mass = MASS_W'($urandom_range(0, min_mass));
    bt.moment = MOMENT_W'({$urandom, $urandom});
    return bt;
  endfunction

  function automatic beat_t report_beat();
    beat_t bt;
    bt.command = CMD_REPORT;
    bt.lane = LANE_W'($urandom);
    bt.mass = MASS_W'($urandom);
    bt.moment = MOMENT_W'({$urandom, $urandom});
    return bt;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_GATE_TOP:     gate_top = val[GATE_W-1:0];
      REG_GATE_BOTTOM:  gate_bottom = val[GATE_W-1:0];
      REG_MIN_MASS:     min_mass = val[MASS_W-1:0];
      REG_NEAR_MARGIN:  near_margin = val[MARGIN_W-1:0];
      REG_CLEAR_MARGIN: clear_margin = val[MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_config(int top, int bot, int mm, int nm, int cm);
    write_reg(REG_GATE_TOP, CFG_DATA_W'(top));
    write_reg(REG_GATE_BOTTOM, CFG_DATA_W'(bot));
    write_reg(REG_MIN_MASS, CFG_DATA_W'(mm));
    write_reg(REG_NEAR_MARGIN, CFG_DATA_W'(nm));
    write_reg(REG_CLEAR_MARGIN, CFG_DATA_W'(cm));
  endtask

  // Hold until every queued beat is accepted and every result is back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || tally_q.size() != 0);
    repeat (50) @(negedge clk);
  endtask

  // Mostly gate crossings on random lanes, the rest reports, stray lanes and noise
  task automatic queue_phase(int n);
    int made, pick, ln, steps, a, b, row, lo, hi, k;
    beat_t bt;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        ln = $urandom_range(0, LANES - 1);
        steps = $urandom_range(3, 8);
        lo = int'(gate_top);
        hi = int'(gate_bottom) + int'(near_margin) + 40;
        if (hi > ROW_TOP) hi = ROW_TOP;
        if (hi < lo) hi = lo;
        if ($urandom_range(0, 1)) begin
          a = hi;
          b = lo;
        end else begin
          a = lo;
          b = hi;
        end
        for (k = 0; k < steps; k++) begin
          row = a + (b - a) * k / (steps - 1) + int'($urandom_range(0, 6)) - 3;
          bt = ($urandom_range(0, 7) == 0) ? light(ln) : aim(ln, row);
          pending_beats.push_back(bt);
          made++;
        end
      end else if (pick == 6) begin
        pending_beats.push_back(report_beat());
        made++;
      end else if (pick == 7) begin
        pending_beats.push_back(aim($urandom_range(LANES, 31), $urandom_range(0, ROW_TOP)));
        made++;
      end else begin
        bt.command = CMD_OBSERVE;
        bt.lane = LANE_W'($urandom);
        bt.mass = MASS_W'($urandom);
        bt.moment = MOMENT_W'({$urandom, $urandom});
        pending_beats.push_back(bt);
        made++;
      end
    end
  endtask

  // Driver: predict on acceptance, hold a stalled beat, then idle or present the next
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && !in_stall) tally_q.push_back(tally_beat(cur_beat));
      if (in_valid && in_stall) begin
        // hold the beat
      end else if (idle_left > 0) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        cur_beat = pending_beats.pop_front();
        command <= cur_beat.command;
        lane <= cur_beat.lane;
        mass_sum <= cur_beat.mass;
        row_moment_sum <= cur_beat.moment;
        in_valid <= 1'b1;
        idle_left = draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tally_q.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing expected: entries %0d exits %0d row %0d",
                                  entries, exits, tracked_row));
        end else begin
          want = tally_q.pop_front();
          if (entries !== want.entries || exits !== want.exits || tracked_row !== want.row)
            flag_mismatch($sformatf("expected entries %0d exits %0d row %0d, got %0d %0d %0d",
                                    want.entries, want.exits, want.row,
                                    entries, exits, tracked_row));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = draw_gap();
      end
    end
  end

  initial begin
    int p, k;
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_OBSERVE;
    lane = '0;
    mass_sum = '0;
    row_moment_sum = '0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    errors = 0;
    gate_top = GATE_TOP_RST;
    gate_bottom = GATE_BOTTOM_RST;
    min_mass = MIN_MASS_RST;
    near_margin = NEAR_MARGIN_RST;
    clear_margin = CLEAR_MARGIN_RST;
    for (k = 0; k < LANES; k++) begin
      latest_row[k] = '0;
      older_row[k] = '0;
      lane_latched[k] = 1'b0;
    end
    entry_cnt = '0;
    exit_cnt = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed beats under the reset settings
    pending_beats.push_back(report_beat());
    pending_beats.push_back('{CMD_OBSERVE, 5'd0, 27'd0, 36'd0});
    pending_beats.push_back('{CMD_OBSERVE, 5'd0, 27'd400, '1});
    pending_beats.push_back(aim(1, 400));
    pending_beats.push_back(aim(1, 310));
    pending_beats.push_back(light(1));
    pending_beats.push_back(aim(1, 305));
    pending_beats.push_back('{CMD_OBSERVE, 5'd2, '1, 36'd0});
    pending_beats.push_back(aim(2, 320));
    pending_beats.push_back(light(2));
    pending_beats.push_back(aim(2, 311));
    pending_beats.push_back('{CMD_OBSERVE, 5'd19, 27'd401, '1});
    pending_beats.push_back('{CMD_OBSERVE, 5'd19, '1, '1});
    pending_beats.push_back(aim(20, 310));
    pending_beats.push_back('{CMD_OBSERVE, 5'd31, '1, '1});
    pending_beats.push_back(report_beat());
    pending_beats.push_back(report_beat());
    wait_idle();

    // Random phases: extremes first, then inverted gates, then moderate settings
    for (p = 0; p < 6; p++) begin
      case (p)
        0: write_config(0, 0, 0, 0, 0);
        1: write_config(479, 479, 78336000, 255, 255);
        2: write_config(400, 100, $urandom_range(0, 1000), 200, 10);
        default: begin
          k = $urandom_range(0, 300);
          write_config(k, k + $urandom_range(40, 179), $urandom_range(0, 3000),
                       $urandom_range(0, 60), $urandom_range(0, 40));
        end
      endcase
      calm = (p == 4);
      queue_phase(100);
      wait_idle();
    end

    $display("covered %0d observations (%0d on lanes out of range) and %0d reports",
             n_obs, n_stray, n_reports);
    $display("predicted %0d entries and %0d exits; saturation of counts %s",
             n_entries, n_exits, count_saturated ? "reached" : "not reached");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
rtl/lcc_pkg.sv
rtl/lcc_div.sv
rtl/lane_crossing_counter_unit.sv
rtl/lcc_chk.sv
sim/lane_crossing_counter_unit_tb.sv
